@@ rtl/cct_pkg.sv @@
`timescale 1ns / 1ps

package cct_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MILLI_W  = 10;
    localparam int INC_W    = 12;

    // Packed payload widths, padded to whole bytes
    localparam int FIELDS_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W + MILLI_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Request kinds carried in tuser
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // Time limits
    localparam int MS_PER_SEC   = 1000;
    localparam int SEC_PER_MIN  = 60;
    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;
    localparam int MONTHS       = 12;
    localparam int YEAR_LAST    = 9999;
    localparam int FEB          = 2;
    localparam int FEB_LEAP_LEN = 29;

    // Largest whole-second carry out of the millisecond stage
    localparam int MS_SUM_W     = INC_W + 1;
    localparam int MS_CARRY_MAX = ((1 << MILLI_W) - 1 + (1 << INC_W) - 1) / MS_PER_SEC;
    localparam int MS_CARRY_W   = $clog2(MS_CARRY_MAX + 1);

    // Reset values
    localparam logic [YEAR_W-1:0]   YEAR_RST  = YEAR_W'(2000);
    localparam logic [MONTH_W-1:0]  MONTH_RST = MONTH_W'(1);
    localparam logic [DAY_W-1:0]    DAY_RST   = DAY_W'(1);
    localparam logic [INC_W-1:0]    INC_RST   = INC_W'(2);

    // Reciprocal of 100 scaled by 2^19, exact for every 14-bit year
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_100   = 5243;
    localparam int PROD_W      = YEAR_W + RECIP_SHIFT - 6;
    localparam int Q100_W      = PROD_W - RECIP_SHIFT;

    typedef struct packed {
        logic [MILLI_W-1:0]  milli;
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } stamp_t;

    typedef logic [DAY_W-1:0] month_len_t [0:MONTHS];

    localparam month_len_t MONTH_LEN = '{
        DAY_W'(0),  DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30),
        DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(31), DAY_W'(30),
        DAY_W'(31), DAY_W'(30), DAY_W'(31)
    };

    // Gregorian leap year: quotient by 100 through a reciprocal multiply
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [Q100_W-1:0] q;
        logic [YEAR_W:0]   back;
        logic              div100;
        logic              div400;
        prod   = PROD_W'(y) * PROD_W'(RECIP_100);
        q      = prod[PROD_W-1:RECIP_SHIFT];
        back   = (YEAR_W + 1)'(q) * (YEAR_W + 1)'(100);
        div100 = (back == {1'b0, y});
        div400 = div100 && (q[1:0] == 2'b00);
        return div400 || ((y[1:0] == 2'b00) && !div100);
    endfunction

    // Month length; months outside the calendar count as 31 days
    function automatic logic [DAY_W-1:0] days_in_month(input logic [YEAR_W-1:0]  y,
                                                        input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        if ((m < MONTH_W'(1)) || (m > MONTH_W'(MONTHS)))
            len = DAY_W'(31);
        else if ((m == MONTH_W'(FEB)) && is_leap(y))
            len = DAY_W'(FEB_LEAP_LEN);
        else
            len = MONTH_LEN[m];
        return len;
    endfunction

endpackage

@@ rtl/calendar_clock_tick_unit.sv @@
`timescale 1ns / 1ps
// An accepted input transaction's result goes to the result register, or to the skid
// register while the output stalls. One transaction per cycle while s_tready is high; the time
// registers update in one pass through the millisecond-to-year carry logic at the accept edge.
// A two-entry output stage (result register plus skid register) keeps s_tready high
// while one result waits. Reset (rst_n low) sets 2000-01-01 00:00:00.000, increment 2 ms.
module calendar_clock_tick_unit
    import cct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // set_year, set_month, set_day, set_hour, set_minute, set_second,
    // set_millisecond (lowest bits first), zero padded
    input  logic [TDATA_W-1:0]    s_tdata,
    input  logic                  s_tuser,   // req_type
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
    // cur_millisecond (lowest bits first), zero padded
    output logic [TDATA_W-1:0]    m_tdata,
    output logic                  m_tuser,   // day_rolled
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [INC_W-1:0]   inc_reg;
    stamp_t             now_reg;
    stamp_t             now_next;
    logic               rolled_next;

    logic [TDATA_W-1:0] out_data_reg;
    logic               out_user_reg;
    logic               out_valid_reg;
    logic [TDATA_W-1:0] skid_data_reg;
    logic               skid_user_reg;
    logic               skid_valid_reg;

    logic               in_fire;
    logic               out_free;
    logic               inc_sel;
    stamp_t             set_stamp;
    logic [TDATA_W-1:0] res_data;

    logic [MS_SUM_W-1:0]   ms_sum;
    logic [MS_CARRY_W-1:0] ms_carry;
    logic [MS_SUM_W-1:0]   ms_rem;
    logic [SECOND_W:0]     sec_sum;
    logic                  sec_carry;
    logic [MINUTE_W:0]     min_sum;
    logic                  min_carry;
    logic [HOUR_W:0]       hour_sum;
    logic                  hour_carry;
    logic [DAY_W-1:0]      month_len;
    logic [MONTH_W:0]      month_inc;

    // Configuration register
    assign pready  = 1'b1;
    assign inc_sel = (paddr[APB_ADDR_W-1:2] == '0);
    assign prdata  = inc_sel ? APB_DATA_W'(inc_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inc_reg <= INC_RST;
        else if (psel && penable && pwrite && pready && inc_sel)
            inc_reg <= pwdata[INC_W-1:0];
    end

    // Unpack the set fields
    assign set_stamp = s_tdata[FIELDS_W-1:0];

    // Advance the clock by one tick, or load the set fields on a set request
    always_comb
    begin
        ms_sum   = MS_SUM_W'(now_reg.milli) + MS_SUM_W'(inc_reg);
        ms_carry = '0;
        for (int k = 1; k <= MS_CARRY_MAX; k++)
        begin
            if (ms_sum >= MS_SUM_W'(k * MS_PER_SEC))
                ms_carry = MS_CARRY_W'(k);
        end
        ms_rem = ms_sum - MS_SUM_W'(ms_carry) * MS_SUM_W'(MS_PER_SEC);

        sec_sum   = (SECOND_W + 1)'(now_reg.second) + (SECOND_W + 1)'(ms_carry);
        sec_carry = (sec_sum >= (SECOND_W + 1)'(SEC_PER_MIN));
        if (sec_carry)
            sec_sum = sec_sum - (SECOND_W + 1)'(SEC_PER_MIN);

        min_sum   = (MINUTE_W + 1)'(now_reg.minute) + (MINUTE_W + 1)'(sec_carry);
        min_carry = (min_sum >= (MINUTE_W + 1)'(MIN_PER_HOUR));
        if (min_carry)
            min_sum = min_sum - (MINUTE_W + 1)'(MIN_PER_HOUR);

        hour_sum   = (HOUR_W + 1)'(now_reg.hour) + (HOUR_W + 1)'(min_carry);
        hour_carry = (hour_sum >= (HOUR_W + 1)'(HOUR_PER_DAY));
        if (hour_carry)
            hour_sum = hour_sum - (HOUR_W + 1)'(HOUR_PER_DAY);

        month_len = days_in_month(now_reg.year, now_reg.month);
        month_inc = (MONTH_W + 1)'(now_reg.month) + (MONTH_W + 1)'(1);

        now_next        = now_reg;
        now_next.milli  = ms_rem[MILLI_W-1:0];
        now_next.second = sec_sum[SECOND_W-1:0];
        now_next.minute = min_sum[MINUTE_W-1:0];
        now_next.hour   = hour_sum[HOUR_W-1:0];
        rolled_next     = hour_carry;

        // Roll the date on a day carry
        if (hour_carry)
        begin
            if (now_reg.day < month_len)
                now_next.day = now_reg.day + DAY_W'(1);
            else
            begin
                now_next.day = DAY_W'(1);
                if (month_inc > (MONTH_W + 1)'(MONTHS))
                begin
                    now_next.month = MONTH_W'(1);
                    if (now_reg.year >= YEAR_W'(YEAR_LAST))
                        now_next.year = '0;
                    else
                        now_next.year = now_reg.year + YEAR_W'(1);
                end
                else
                    now_next.month = month_inc[MONTH_W-1:0];
            end
        end

        // Load the set fields instead
        if (s_tuser == REQ_SET)
        begin
            now_next    = set_stamp;
            rolled_next = 1'b0;
        end
    end

    // Time registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg.year   <= YEAR_RST;
            now_reg.month  <= MONTH_RST;
            now_reg.day    <= DAY_RST;
            now_reg.hour   <= '0;
            now_reg.minute <= '0;
            now_reg.second <= '0;
            now_reg.milli  <= '0;
        end
        else if (in_fire)
            now_reg <= now_next;
    end

    // Output stage with skid register
    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign res_data = TDATA_W'(now_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
            out_user_reg <= skid_valid_reg ? skid_user_reg : rolled_next;
        end
        else if (in_fire)
        begin
            skid_data_reg <= res_data;
            skid_user_reg <= rolled_next;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/cct_checker.sv @@
`timescale 1ns / 1ps
module cct_checker
    import cct_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic [TDATA_W-1:0]    s_tdata,
    input logic                  s_tuser,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [TDATA_W-1:0]    m_tdata,
    input logic                  m_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Every accepted transaction leaves m_tvalid high on the next cycle
    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted transaction produced no result");

    // Input back-pressure only while a result waits
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && $past(m_tvalid && !m_tready))
        else $error("input stalled with output free");

    // A set transaction into a free output is echoed with no rollover
    a_set_echo: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == REQ_SET) && (!m_tvalid || m_tready)
        |=> (m_tdata[FIELDS_W-1:0] == $past(s_tdata[FIELDS_W-1:0])) && !m_tuser)
        else $error("set transaction not echoed");

    // Pad bits of the result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[TDATA_W-1:FIELDS_W] == '0))
        else $error("result pad bits set");

endmodule

bind calendar_clock_tick_unit cct_checker u_cct_checker (.*);
